// File: src/fild_pkg.sv
// shared constants, codes and control types for the front-insert list
package fild_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int VAL_W   = 32;
  localparam int POS_W   = 6;

  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_DELETE   = 2'd1,
    KIND_TRAVERSE = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DELETED   = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_CLEARED   = 3'd4,
    STAT_ELEMENT   = 3'd5,
    STAT_EMPTY     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_CMP,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEL,
    ST_TRAV
  } state_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] key;
    logic signed [31:0] head;
    logic [CNT_W-1:0]   count;
  } cell_ctl_t;

endpackage

// File: src/fild_cell.sv
// one list cell: holds one entry and its match flag, shifts with its neighbors
module fild_cell
  import fild_pkg::*;
(
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic [IDX_W-1:0]        idx,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic signed [VAL_W-1:0] right_val,
  input  logic                    found_in,
  output logic                    found_out,
  output logic signed [VAL_W-1:0] value
);

  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic                    match_r, match_nxt;
  logic                    occ;
  logic                    is_tail;

  assign occ       = CNT_W'(idx) < ctl.count;
  assign is_tail   = (CNT_W'(idx) + CNT_W'(1)) == ctl.count;
  assign found_out = found_in | match_r;
  assign value     = value_r;

  always_comb begin
    value_nxt = value_r;
    match_nxt = match_r;
    unique case (ctl.op)
      CELL_INS: value_nxt = left_val;
      CELL_CMP: match_nxt = occ && (value_r == ctl.key);
      CELL_DEL: begin
        // this cell and all behind the first match close the gap
        if (found_out) value_nxt = right_val;
      end
      CELL_ROT: value_nxt = is_tail ? ctl.head : right_val;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    match_r <= match_nxt;
  end

endmodule

// File: src/fild_chain.sv
// row of list cells, front cell first
module fild_chain
  import fild_pkg::*;
(
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  output logic signed [VAL_W-1:0] head_val,
  output logic                    any_found
);

  logic signed [VAL_W-1:0] vals  [DEPTH];
  logic                    found [DEPTH+1];

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fild_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (IDX_W'(i)),
      .left_val  ((i == 0) ? ctl.key : vals[(i == 0) ? 0 : i-1]),
      .right_val ((i == DEPTH-1) ? ctl.head : vals[(i == DEPTH-1) ? i : i+1]),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .value     (vals[i])
    );
  end

  assign head_val  = vals[0];
  assign any_found = found[DEPTH];

endmodule

// File: src/front_insert_list_delete_by_value.sv
// top level of the bounded front-insert list with delete by value
//
// input channel (in_valid/in_ready, in_kind, in_value) takes one operation per
// transaction: insert at front, delete first match, traverse, or clear.
// result channel (out_valid/out_ready, out_status, out_item_value,
// out_position, out_last) returns the results; out_last marks the final one.
// the entries live in a row of cells that shift as one: insert moves every
// entry back by a cell, delete closes the gap behind the first match, and a
// traversal rotates the row toward the front, emitting the front cell.
// latency: insert, clear, full insert, empty traverse give their result the
// cycle after acceptance; delete compares in every cell, then does the
// first-match chain and shift once the output register is free; a traversal
// of n entries emits one element per cycle while the receiver takes them.
// throughput: one transaction per cycle for insert and clear while the
// receiver keeps up; delete and traversal hold in_ready low until done.
// a single output register parts the channels; a new transaction is taken
// while the previous result is being drained in the same cycle.
// reset empties the list and drops any pending result; a stalled receiver
// simply holds the output register and the sequencer.
module front_insert_list_delete_by_value
  import fild_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_kind,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              out_status,
  output logic signed [VAL_W-1:0] out_item_value,
  output logic [POS_W-1:0]        out_position,
  output logic                    out_last
);

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0] out_item_r, out_item_nxt;
  logic [POS_W-1:0]        out_pos_r, out_pos_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    slot_free;
  logic                    accept;
  logic                    load;
  logic                    trav_last;
  kind_t                   kind;
  cell_ctl_t               ctl;
  logic signed [VAL_W-1:0] head_val;
  logic                    any_found;

  assign kind      = kind_t'(in_kind);
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign trav_last = (CNT_W'(pos_r) + CNT_W'(1)) == count_r;

  fild_chain u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .head_val  (head_val),
    .any_found (any_found)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && kind == KIND_DELETE) begin
          state_nxt = ST_DEL;
        end else if (accept && kind == KIND_TRAVERSE && count_r != '0) begin
          state_nxt = ST_TRAV;
        end
      end
      ST_DEL:  if (slot_free) state_nxt = ST_IDLE;
      ST_TRAV: if (slot_free && trav_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control and result
  always_comb begin
    ctl.op         = CELL_HOLD;
    ctl.key        = in_value;
    ctl.head       = head_val;
    ctl.count      = count_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    load           = 1'b0;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt      = in_value;
          out_item_nxt = in_value;
          out_pos_nxt  = '0;
          out_last_nxt = 1'b1;
          unique case (kind)
            KIND_INSERT: begin
              load = 1'b1;
              if (count_r == CNT_W'(DEPTH)) begin
                out_status_nxt = STAT_FULL;
              end else begin
                ctl.op         = CELL_INS;
                count_nxt      = count_r + CNT_W'(1);
                out_status_nxt = STAT_INSERTED;
              end
            end
            KIND_DELETE: ctl.op = CELL_CMP;
            KIND_TRAVERSE: begin
              pos_nxt = '0;
              if (count_r == '0) begin
                load           = 1'b1;
                out_status_nxt = STAT_EMPTY;
              end
            end
            KIND_CLEAR: begin
              load           = 1'b1;
              count_nxt      = '0;
              out_status_nxt = STAT_CLEARED;
            end
            default: ;
          endcase
        end
      end
      ST_DEL: begin
        if (slot_free) begin
          load         = 1'b1;
          out_item_nxt = key_r;
          out_pos_nxt  = '0;
          out_last_nxt = 1'b1;
          if (any_found) begin
            ctl.op         = CELL_DEL;
            count_nxt      = count_r - CNT_W'(1);
            out_status_nxt = STAT_DELETED;
          end else begin
            out_status_nxt = STAT_NOT_FOUND;
          end
        end
      end
      ST_TRAV: begin
        if (slot_free) begin
          // front cell goes out, the row rotates behind it
          load           = 1'b1;
          ctl.op         = CELL_ROT;
          out_status_nxt = STAT_ELEMENT;
          out_item_nxt   = head_val;
          out_pos_nxt    = POS_W'(pos_r);
          out_last_nxt   = trav_last;
          pos_nxt        = pos_r + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_item_value = out_item_r;
  assign out_position   = out_pos_r;
  assign out_last       = out_last_r;

endmodule

// File: src/fild_checker.sv
// port-level checks for the front-insert list, bound to the top level
module fild_checker
  import fild_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [1:0]              in_kind,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [2:0]              out_status,
  input logic signed [VAL_W-1:0] out_item_value,
  input logic [POS_W-1:0]        out_position,
  input logic                    out_last
);

  // stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled payload holds
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_item_value)
      && $stable(out_position) && $stable(out_last))
    else $error("result payload changed while stalled");

  // a traversal still in flight blocks new transactions
  a_trav_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken during traversal");

  // clear answers in the next cycle
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_CLEAR |=>
      out_valid && out_last && out_status == STAT_CLEARED)
    else $error("clear result missing");

endmodule

bind front_insert_list_delete_by_value fild_checker u_fild_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_kind        (in_kind),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_item_value (out_item_value),
  .out_position   (out_position),
  .out_last       (out_last)
);

// File: bench/front_insert_list_delete_by_value_tb.sv
// self-checking testbench for the bounded front-insert list with delete by value
`timescale 1ns / 100ps

module front_insert_list_delete_by_value_tb;
  import fild_pkg::*;

  // one expected transaction on the result channel
  typedef struct {
    status_t            status;
    logic signed [31:0] item_value;
    logic [POS_W-1:0]   position;
    logic               last;
  } list_result_t;

  // random operation mixes, switched every segment of the random part
  typedef enum {
    MIX_FILL,
    MIX_DRAIN,
    MIX_ANY
  } op_mix_t;

  localparam int RANDOM_ITEMS  = 345;
  localparam int SEGMENT_LEN   = 25;
  localparam int QUIET_ITEMS   = 40;
  localparam int HOLD_CYCLES   = 60;
  localparam int DRAIN_CYCLES  = 8;

  // keeps a mirror of the list and the queue of results still owed by the block
  class list_scoreboard;
    logic signed [31:0] contents[$];
    list_result_t       awaited[$];
    int                 errors;

    // work out what an accepted input transaction must produce
    function void note_op(kind_t kind, logic signed [31:0] value);
      int           hit;
      bit           single;
      list_result_t r;
      hit          = -1;
      single       = 1'b1;
      r.item_value = value;
      r.position   = '0;
      r.last       = 1'b1;
      case (kind)
        KIND_INSERT: begin
          if (contents.size() >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            contents.push_front(value);
            r.status = STAT_INSERTED;
          end
        end
        KIND_DELETE: begin
          // first match counted from the front
          foreach (contents[i]) begin
            if (hit < 0 && contents[i] == value) hit = i;
          end
          if (hit < 0) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            contents.delete(hit);
            r.status = STAT_DELETED;
          end
        end
        KIND_TRAVERSE: begin
          if (contents.size() == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            single = 1'b0;
            foreach (contents[i]) begin
              r.status     = STAT_ELEMENT;
              r.item_value = contents[i];
              r.position   = POS_W'(i);
              r.last       = (i == contents.size() - 1);
              awaited.push_back(r);
            end
          end
        end
        default: begin
          contents.delete();
          r.status = STAT_CLEARED;
        end
      endcase
      if (single) awaited.push_back(r);
    endfunction

    // compare one accepted result against the oldest expectation
    function void check_result(logic [2:0] status, logic signed [31:0] item_value,
                               logic [POS_W-1:0] position, logic last);
      list_result_t e;
      if (awaited.size() == 0) begin
        $error("unexpected result: status %0d item_value %0d position %0d last %0d",
               status, item_value, position, last);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (status !== e.status) begin
        $error("status mismatch: expected %0d, actual %0d", e.status, status);
        errors++;
      end
      if (item_value !== e.item_value) begin
        $error("item_value mismatch: expected %0d, actual %0d", e.item_value, item_value);
        errors++;
      end
      if (position !== e.position) begin
        $error("position mismatch: expected %0d, actual %0d", e.position, position);
        errors++;
      end
      if (last !== e.last) begin
        $error("last mismatch: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  kind_t                   in_kind = KIND_INSERT;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [2:0]              out_status;
  logic signed [VAL_W-1:0] out_item_value;
  logic [POS_W-1:0]        out_position;
  logic                    out_last;

  list_scoreboard sb = new();

  // idle rates in percent, changed per segment by the stimulus
  int gap_pct   = 0;
  int stall_pct = 0;
  // asks the receiver for one long hold-off
  bit hold_req  = 1'b0;

  front_insert_list_delete_by_value dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_item_value (out_item_value),
    .out_position   (out_position),
    .out_last       (out_last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // both channels are sampled at the rising edge, before any driven update lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result(out_status, out_item_value, out_position, out_last);
      if (in_valid && in_ready)
        sb.note_op(in_kind, in_value);
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long stretch with the result channel blocked, so the block backs up
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0 && stall_pct != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(12, 1) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // offer one transaction, with an optional idle burst first, and wait for acceptance
  task automatic send_op(input kind_t kind, input logic signed [31:0] value);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // small values collide often, which exercises duplicates and matches
  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return $signed($urandom_range(6)) - 3;
    if (r < 45) begin
      case ($urandom_range(3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  // mostly a value currently in the list, so deletes hit
  function automatic logic signed [31:0] pick_delete_value();
    if (sb.contents.size() != 0 && $urandom_range(99) < 75)
      return sb.contents[$urandom_range(sb.contents.size() - 1)];
    return pick_value();
  endfunction

  // draw one operation kind according to the current mix
  function automatic kind_t pick_kind(op_mix_t mix);
    int unsigned r;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        if (r < 85) return KIND_INSERT;
        if (r < 93) return KIND_DELETE;
        return KIND_TRAVERSE;
      end
      MIX_DRAIN: begin
        if (r < 65) return KIND_DELETE;
        if (r < 82) return KIND_INSERT;
        if (r < 97) return KIND_TRAVERSE;
        return KIND_CLEAR;
      end
      default: begin
        if (r < 40) return KIND_INSERT;
        if (r < 70) return KIND_DELETE;
        if (r < 93) return KIND_TRAVERSE;
        return KIND_CLEAR;
      end
    endcase
  endfunction

  // stimulus and end of run
  initial begin
    op_mix_t mix;
    kind_t   kind;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part: empty-list cases first
    send_op(KIND_TRAVERSE, 32'sd99);
    send_op(KIND_DELETE, 32'sd5);
    // field extremes and a duplicate pair
    send_op(KIND_INSERT, 32'sh8000_0000);
    send_op(KIND_INSERT, 32'sh7fff_ffff);
    send_op(KIND_INSERT, 32'sd0);
    send_op(KIND_INSERT, -32'sd1);
    send_op(KIND_INSERT, 32'sd7);
    send_op(KIND_INSERT, 32'sd7);
    send_op(KIND_TRAVERSE, 32'sd0);
    // duplicate delete removes only the front copy; then a miss, then the back entry
    send_op(KIND_DELETE, 32'sd7);
    send_op(KIND_DELETE, 32'sd12345);
    send_op(KIND_DELETE, 32'sh8000_0000);
    // fill to capacity, then a refused insert and a full traversal
    while (sb.contents.size() < DEPTH) send_op(KIND_INSERT, pick_value());
    send_op(KIND_INSERT, 32'sh5a5a_a5a5);
    send_op(KIND_TRAVERSE, 32'sd0);
    send_op(KIND_CLEAR, -32'sd2);
    send_op(KIND_TRAVERSE, 32'sh7fff_ffff);

    // receiver blocks for a long stretch while the sender keeps offering
    hold_req = 1'b1;
    repeat (6) send_op(KIND_INSERT, pick_value());
    send_op(KIND_TRAVERSE, pick_value());

    // random part in segments with their own mix and idle rates
    mix = MIX_FILL;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_LEN == 0) begin
        if (n != 0) mix = op_mix_t'($urandom_range(2));
        case ($urandom_range(2))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          default: gap_pct = 35;
        endcase
        case ($urandom_range(2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      // closing stretch runs at full rate on both sides
      if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      kind = pick_kind(mix);
      if (kind == KIND_DELETE) send_op(kind, pick_delete_value());
      else send_op(kind, pick_value());
    end
    in_valid <= 1'b0;

    // wait for every owed result, then watch for strays
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("front_insert_list_delete_by_value_tb passed");
    end else begin
      $display("front_insert_list_delete_by_value_tb failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("front_insert_list_delete_by_value_tb failed");
    $finish;
  end

endmodule
